@@ src/comment_stripping_statement_splitter_top_assert.svh @@
// Assertion macros shared by the checker of the comment stripping statement splitter.
`ifndef COMMENT_STRIPPING_STATEMENT_SPLITTER_TOP_ASSERT_SVH
`define COMMENT_STRIPPING_STATEMENT_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cssp_pkg.sv @@
// Package with types and constants of the comment stripping statement splitter.
package cssp_pkg;

    // Result kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_MARK = 1'b1;

    // Statement modes.
    localparam logic MODE_LINE = 1'b0;
    localparam logic MODE_SEMI = 1'b1;

    // Characters the scanner reacts to.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Scanner phases.
    typedef enum logic [2:0] {
        PH_NORMAL       = 3'd0,
        PH_SLASH        = 3'd1,
        PH_LINE_COMMENT = 3'd2,
        PH_BLOCK        = 3'd3,
        PH_BLOCK_STAR   = 3'd4
    } t_phase;

    // One result item.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_result;

    // One queued work entry: one or two results caused by an input item.
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ src/cssp_ifs.sv @@
// Channel interfaces of the comment stripping statement splitter.

// Input byte channel.
interface cssp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// Result channel.
interface cssp_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_kind, output out_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input out_kind, input out_byte, input last_of_run,
                  output ready);
endinterface

// Configuration write channel.
interface cssp_cfg_if;
    logic valid;
    logic ready;
    logic statement_mode;

    modport source (output valid, output statement_mode, input ready);
    modport sink (input valid, input statement_mode, output ready);
endinterface

@@ src/cssp_front.sv @@
// Front part: accepts bytes, tracks the comment scanner and forms queue entries.
module cssp_front
    import cssp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cssp_in_if.sink       in_ch,
    cssp_cfg_if.sink      cfg_ch,
    input  t_queue_status i_status,
    output logic          o_push,
    output t_entry        o_entry
);

    logic   r_mode;
    t_phase r_phase;
    logic   r_started;

    t_phase  n_phase;
    logic    n_started;
    logic    has_result;
    logic    two_results;
    t_result res0;
    t_result res1;
    logic    accept;
    logic [7:0] b;

    // Configuration writes are always taken.
    assign cfg_ch.ready = 1'b1;

    assign in_ch.ready = !i_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.in_byte;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINE;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            r_mode <= cfg_ch.statement_mode;
        end
    end

    // Scanner state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NORMAL;
            r_started <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_started <= n_started;
        end
    end

    // Next phase and the results caused by the current byte.
    always_comb begin
        n_phase     = r_phase;
        n_started   = r_started;
        has_result  = 1'b0;
        two_results = 1'b0;
        res0        = '{kind: KIND_TEXT, data: CH_NUL};
        res1        = '{kind: KIND_TEXT, data: CH_NUL};
        if (in_ch.end_of_text) begin
            // End of text: flush a pending slash and close an open statement.
            if (r_phase == PH_SLASH) begin
                has_result  = 1'b1;
                two_results = 1'b1;
                res0        = '{kind: KIND_TEXT, data: CH_SLASH};
                res1        = '{kind: KIND_MARK, data: CH_NUL};
            end else if (r_started) begin
                has_result = 1'b1;
                res0       = '{kind: KIND_MARK, data: CH_NUL};
            end
            n_phase   = PH_NORMAL;
            n_started = 1'b0;
        end else begin
            unique case (r_phase)
                PH_SLASH: begin
                    if (b == CH_SLASH) begin
                        n_phase = PH_LINE_COMMENT;
                    end else if (b == CH_STAR) begin
                        n_phase = PH_BLOCK;
                    end else begin
                        // Lone slash: keep it and copy the next byte literally.
                        n_phase     = PH_NORMAL;
                        has_result  = 1'b1;
                        two_results = 1'b1;
                        res0        = '{kind: KIND_TEXT, data: CH_SLASH};
                        res1        = '{kind: KIND_TEXT, data: b};
                        n_started   = 1'b1;
                    end
                end
                PH_LINE_COMMENT: begin
                    if (b == CH_LF) begin
                        n_phase = PH_NORMAL;
                        if (r_mode == MODE_LINE) begin
                            has_result = 1'b1;
                            res0       = '{kind: KIND_MARK, data: CH_NUL};
                            n_started  = 1'b0;
                        end
                    end
                end
                PH_BLOCK: begin
                    if (b == CH_STAR) begin
                        n_phase = PH_BLOCK_STAR;
                    end
                end
                PH_BLOCK_STAR: begin
                    if (b == CH_SLASH) begin
                        n_phase = PH_NORMAL;
                    end else if (b != CH_STAR) begin
                        n_phase = PH_BLOCK;
                    end
                end
                default: begin
                    // Normal text; unused codes behave the same way.
                    n_phase = PH_NORMAL;
                    if (b == CH_SLASH) begin
                        n_phase = PH_SLASH;
                    end else if (r_mode == MODE_LINE) begin
                        if (b == CH_LF || b == CH_CR) begin
                            has_result = 1'b1;
                            res0       = '{kind: KIND_MARK, data: CH_NUL};
                            n_started  = 1'b0;
                        end else if (b == CH_SEMI) begin
                            n_phase = PH_LINE_COMMENT;
                        end else begin
                            has_result = 1'b1;
                            res0       = '{kind: KIND_TEXT, data: b};
                            n_started  = 1'b1;
                        end
                    end else begin
                        has_result = 1'b1;
                        if (b == CH_SEMI) begin
                            res0      = '{kind: KIND_MARK, data: CH_NUL};
                            n_started = 1'b0;
                        end else if (b == CH_LF || b == CH_CR) begin
                            res0      = '{kind: KIND_TEXT, data: CH_SPACE};
                            n_started = 1'b1;
                        end else begin
                            res0      = '{kind: KIND_TEXT, data: b};
                            n_started = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // Only items that cause results enter the queue.
    assign o_push  = accept && has_result;
    assign o_entry = '{two: two_results, first: res0, second: res1};

endmodule

@@ src/cssp_fifo.sv @@
// Short queue of work entries between the front and the back.
module cssp_fifo
    import cssp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_entry        i_entry,
    input  logic          i_pop,
    output t_entry        o_head,
    output t_queue_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/cssp_back.sv @@
// Back part: presents queued results one per transfer, two for a two-result entry.
module cssp_back
    import cssp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_entry        i_head,
    input  t_queue_status i_status,
    output logic          o_pop,
    cssp_out_if.source    out_ch
);

    logic    r_second;
    logic    n_second;
    t_result sel;
    logic    xfer;
    logic    last;

    // Pick the result of the head entry that is due now.
    assign sel  = r_second ? i_head.second : i_head.first;
    assign last = !i_head.two || r_second;

    assign out_ch.valid       = !i_status.empty;
    assign out_ch.out_kind    = sel.kind;
    assign out_ch.out_byte    = sel.data;
    assign out_ch.last_of_run = last;

    assign xfer  = out_ch.valid && out_ch.ready;
    assign o_pop = xfer && last;

    // Second-result flag advances on each transfer.
    always_comb begin
        n_second = r_second;
        if (xfer) begin
            n_second = i_head.two && !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

endmodule

@@ src/comment_stripping_statement_splitter_top.sv @@
// Top level of the comment stripping statement splitter.
//
// Usage: script text enters on i_in, one byte per transfer; end_of_text set
// means no byte and closes an open statement. Kept bytes and end-of-statement
// markers leave on o_out; last_of_run marks the final result of an input item.
// i_cfg writes statement_mode (0 line mode, 1 semicolon mode); it is always
// ready and should be written only while the block is idle.
// Results pass through the queue and are offered on o_out from its head.
// Throughput: one input item per cycle. An item with two results (a lone
// slash, or end of text after a slash) takes two output transfers; the queue of
// QUEUE_DEPTH entries absorbs these, and i_in stalls only when it is full.
// Items that cause no result (comment bytes) take no queue entry.
// Reset clears the scanner to normal text, the mode to line mode and the queue.
// When the receiver stalls, o_out holds its result and the queue fills; i_in
// ready drops once the queue is full and rises when an entry drains.
module comment_stripping_statement_splitter_top
    import cssp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cssp_in_if.sink    i_in,
    cssp_cfg_if.sink   i_cfg,
    cssp_out_if.source o_out
);

    t_queue_status status;
    logic          push;
    logic          pop;
    t_entry        entry;
    t_entry        head;

    // Classifier front end.
    cssp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_ch    (i_in),
        .cfg_ch   (i_cfg),
        .i_status (status),
        .o_push   (push),
        .o_entry  (entry)
    );

    // Work queue.
    cssp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    // Result sequencer.
    cssp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (status),
        .o_pop    (pop),
        .out_ch   (o_out)
    );

endmodule

@@ src/cssp_checker.sv @@
// Port-level checker of the comment stripping statement splitter and its bind.
`include "comment_stripping_statement_splitter_top_assert.svh"

module cssp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_kind,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // A stalled result holds until it is transferred.
    `CSSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_byte) && $stable(i_out_last), "stalled result changed")

    // The second result of an item follows directly after the first.
    `CSSP_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid, "run broken before its last result")

    // A marker carries a zero byte and always ends its item's run.
    `CSSP_ASSERT_IMPL(a_marker_form, i_clk, i_rst_n, i_out_valid && i_out_kind, i_out_last && (i_out_byte == 8'h00), "malformed statement marker")

endmodule

bind comment_stripping_statement_splitter_top cssp_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.out_kind),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_run)
);

@@ tb/comment_stripping_statement_splitter_top_tb.sv @@
// Self-checking testbench for the comment stripping statement splitter top level.
`timescale 1ns / 1ps

module comment_stripping_statement_splitter_top_tb;
    import cssp_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_SETTLE  = 4;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 325;

    // Receiver stall styles.
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_SPARSE  = 3;

    // One expected result of the splitter.
    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_kept_item;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cssp_in_if  in_if ();
    cssp_cfg_if cfg_if ();
    cssp_out_if out_if ();

    comment_stripping_statement_splitter_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_out   (out_if.source)
    );

    // Shadow copy of the scanner state and the mode register.
    logic       shadow_mode = MODE_LINE;
    t_phase     shadow_phase = PH_NORMAL;
    logic       shadow_open = 1'b0;
    t_kept_item kept_text_queue[$];

    int  error_count = 0;
    int  items_sent = 0;
    int  bytes_checked = 0;
    int  marks_checked = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    int  rx_style = RX_RANDOM;
    bit  bursty = 1'b1;
    int  burst_left = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Appends one result of the current item and tracks whether a statement is open.
    function automatic void add_kept(input logic kind, input logic [7:0] data);
        t_kept_item item;
        item.kind = kind;
        item.data = (kind == KIND_MARK) ? CH_NUL : data;
        item.last = 1'b0;
        kept_text_queue.push_back(item);
        shadow_open = (kind == KIND_TEXT);
    endfunction

    // Predicts the results of one accepted input item.
    function automatic void strip_and_split(input logic [7:0] b, input logic text_end);
        int before_count;
        before_count = kept_text_queue.size();
        if (text_end) begin
            if (shadow_phase == PH_SLASH) add_kept(KIND_TEXT, CH_SLASH);
            if (shadow_open) add_kept(KIND_MARK, CH_NUL);
            shadow_phase = PH_NORMAL;
            shadow_open = 1'b0;
        end else begin
            case (shadow_phase)
                PH_SLASH: begin
                    if (b == CH_SLASH) begin
                        shadow_phase = PH_LINE_COMMENT;
                    end else if (b == CH_STAR) begin
                        shadow_phase = PH_BLOCK;
                    end else begin
                        // A lone slash keeps itself and the next byte literally.
                        shadow_phase = PH_NORMAL;
                        add_kept(KIND_TEXT, CH_SLASH);
                        add_kept(KIND_TEXT, b);
                    end
                end
                PH_LINE_COMMENT: begin
                    if (b == CH_LF) begin
                        shadow_phase = PH_NORMAL;
                        if (shadow_mode == MODE_LINE) add_kept(KIND_MARK, CH_NUL);
                    end
                end
                PH_BLOCK: begin
                    if (b == CH_STAR) shadow_phase = PH_BLOCK_STAR;
                end
                PH_BLOCK_STAR: begin
                    if (b == CH_SLASH) shadow_phase = PH_NORMAL;
                    else if (b != CH_STAR) shadow_phase = PH_BLOCK;
                end
                default: begin
                    shadow_phase = PH_NORMAL;
                    if (b == CH_SLASH) begin
                        shadow_phase = PH_SLASH;
                    end else if (shadow_mode == MODE_LINE) begin
                        if (b == CH_LF || b == CH_CR) add_kept(KIND_MARK, CH_NUL);
                        else if (b == CH_SEMI) shadow_phase = PH_LINE_COMMENT;
                        else add_kept(KIND_TEXT, b);
                    end else begin
                        if (b == CH_SEMI) add_kept(KIND_MARK, CH_NUL);
                        else if (b == CH_LF || b == CH_CR) add_kept(KIND_TEXT, CH_SPACE);
                        else add_kept(KIND_TEXT, b);
                    end
                end
            endcase
        end
        if (kept_text_queue.size() > before_count) kept_text_queue[$].last = 1'b1;
    endfunction

    // Captures register writes and input transfers, and checks each output transfer.
    always @(posedge clk) begin
        t_kept_item want;
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) shadow_mode = cfg_if.statement_mode;
            if (in_if.valid && in_if.ready) strip_and_split(in_if.in_byte, in_if.end_of_text);
            if (out_if.valid && out_if.ready) begin
                if (kept_text_queue.size() == 0) begin
                    $display("%0t: unexpected result kind=%0b byte=%02h last=%0b", $time,
                             out_if.out_kind, out_if.out_byte, out_if.last_of_run);
                    error_count++;
                end else begin
                    want = kept_text_queue.pop_front();
                    if (out_if.out_kind !== want.kind || out_if.out_byte !== want.data ||
                        out_if.last_of_run !== want.last) begin
                        $display("%0t: mismatch expected kind=%0b byte=%02h last=%0b, got kind=%0b byte=%02h last=%0b",
                                 $time, want.kind, want.data, want.last,
                                 out_if.out_kind, out_if.out_byte, out_if.last_of_run);
                        error_count++;
                    end
                    if (want.kind == KIND_MARK) marks_checked++;
                    else bytes_checked++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: an optional long hold, then one of several stall styles.
    initial begin : receiver
        logic [7:0] stall_pattern;
        stall_pattern = 8'b1101_1001;
        out_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_ALWAYS:  out_if.ready <= 1'b1;
                    RX_RANDOM:  out_if.ready <= ($urandom_range(0, 9) < 7);
                    RX_PATTERN: out_if.ready <= stall_pattern[0];
                    default:    out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one item and waits for its transfer, with bursts and gaps when enabled.
    task automatic send_item(input logic [7:0] b, input logic text_end);
        int gap;
        if (bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        in_if.valid <= 1'b1;
        in_if.in_byte <= b;
        in_if.end_of_text <= text_end;
        do @(posedge clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_text_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stops offering items until every expected result has arrived.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (kept_text_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    task automatic write_statement_mode(input logic mode);
        cfg_if.valid <= 1'b1;
        cfg_if.statement_mode <= mode;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly letters, sometimes any byte value.
    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends one piece of script text: a well-formed construct most of the time, else noise.
    task automatic send_fragment();
        int pick;
        int len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            len = $urandom_range(1, 6);
            repeat (len) send_byte(text_byte());
        end else if (pick < 45) begin
            case ($urandom_range(0, 2))
                0: send_byte(CH_LF);
                1: send_byte(CH_CR);
                default: send_byte(CH_SEMI);
            endcase
        end else if (pick < 62) begin
            // Line comment opened by a double slash or by a semicolon.
            if (pick < 55) begin
                send_byte(CH_SLASH);
                send_byte(CH_SLASH);
            end else begin
                send_byte(CH_SEMI);
            end
            len = $urandom_range(0, 8);
            repeat (len) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
                send_byte(b);
            end
            send_byte(CH_LF);
        end else if (pick < 74) begin
            // Block comment whose body leans on stars, slashes and newlines.
            send_byte(CH_SLASH);
            send_byte(CH_STAR);
            len = $urandom_range(0, 8);
            repeat (len) begin
                case ($urandom_range(0, 3))
                    0: send_byte(CH_STAR);
                    1: send_byte(CH_LF);
                    2: send_byte(CH_SLASH);
                    default: send_byte(text_byte());
                endcase
            end
            send_byte(CH_STAR);
            send_byte(CH_SLASH);
        end else if (pick < 82) begin
            send_byte(CH_SLASH);
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 90) begin
            send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
            send_text_end();
        end else begin
            // Text that ends inside an open comment or right after a slash.
            send_byte(CH_SLASH);
            if ($urandom_range(0, 1)) begin
                send_byte(CH_STAR);
                send_byte(text_byte());
            end
            send_text_end();
        end
    endtask

    // Line mode: extreme bytes, both terminators, empty statements, semicolon comment.
    task automatic test_line_mode_basics();
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_SEMI);
        send_byte("x");
        send_byte(CH_LF);
        send_text_end();
        wait_for_drain();
    endtask

    // A slash right after the opener does not close a block comment; newlines inside vanish.
    task automatic test_block_comments();
        send_byte(CH_SLASH);
        send_byte(CH_STAR);
        send_byte(CH_SLASH);
        send_byte(CH_LF);
        send_byte(CH_STAR);
        send_byte(CH_STAR);
        send_byte(CH_SLASH);
        send_byte("q");
        send_text_end();
        wait_for_drain();
    endtask

    // Lone slash before a byte and before the end of text.
    task automatic test_lone_slash();
        send_byte(CH_SLASH);
        send_byte("b");
        send_byte(CH_SLASH);
        send_text_end();
        wait_for_drain();
    endtask

    // A line comment opened in line mode closes silently once semicolon mode is set.
    task automatic test_mode_switch_in_comment();
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        wait_for_drain();
        write_statement_mode(MODE_SEMI);
        send_byte(CH_LF);
        send_byte("k");
        send_byte(CH_CR);
        send_byte(CH_SEMI);
        wait_for_drain();
    endtask

    // The end of text inside a block comment still closes the open statement.
    task automatic test_end_in_comment();
        send_byte("z");
        send_byte(CH_SLASH);
        send_byte(CH_STAR);
        send_text_end();
        wait_for_drain();
        write_statement_mode(MODE_LINE);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_receiver_hold();
        bursty = 1'b0;
        hold_cycles = 150;
        repeat (12) begin
            send_byte(text_byte());
            send_byte(CH_SLASH);
            send_byte(text_byte());
        end
        wait_for_drain();
        bursty = 1'b1;
    endtask

    // Random script text over several mode, burst and stall settings.
    task automatic test_random_text();
        int phase_end;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_for_drain();
            case (p)
                0, 3: write_statement_mode(MODE_LINE);
                1, 2: write_statement_mode(MODE_SEMI);
                default: write_statement_mode(1'($urandom_range(0, 1)));
            endcase
            rx_style = p % 4;
            bursty = (p != 2);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) send_fragment();
        end
        rx_style = RX_RANDOM;
        bursty = 1'b1;
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.in_byte = CH_NUL;
        in_if.end_of_text = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.statement_mode = MODE_LINE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_mode_basics();
        test_block_comments();
        test_lone_slash();
        test_mode_switch_in_comment();
        test_end_in_comment();
        test_receiver_hold();
        test_random_text();

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (kept_text_queue.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, kept_text_queue.size());
            error_count++;
        end
        $display("Sent %0d items of script text in line and semicolon mode under stalls.",
                 items_sent);
        $display("Checked %0d kept bytes and %0d statement markers, %0d errors.",
                 bytes_checked, marks_checked, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
